[rtl/core/vehicle_safety_speed_supervisor_defines.svh]
// Assertion macros used by the speed supervisor checker.
`ifndef VEHICLE_SAFETY_SPEED_SUPERVISOR_DEFINES_SVH
`define VEHICLE_SAFETY_SPEED_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VSSS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VSSS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vsss_pkg.sv]
// Types and constants of the vehicle safety speed supervisor.
package vsss_pkg;

  // Emergency cause codes
  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_OBSTACLE  = 3'd1,
    CAUSE_OVERSPEED = 3'd2,
    CAUSE_OVERTEMP  = 3'd3,
    CAUSE_UNDERVOLT = 3'd4
  } cause_e;

  // Input sample beat
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [11:0] temperature;
    logic [15:0]        voltage;
    logic               obstacle;
  } in_t;

  // Result beat
  typedef struct packed {
    logic        shutoff;
    cause_e      cause;
    logic [6:0]  brake_pct;
    logic [14:0] motor_target;
  } out_t;

  // Per-stage advance enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic so;
  } pipe_en_t;

  // Stage 1: checks done, temperature product formed
  typedef struct packed {
    cause_e             cause;
    logic [14:0]        e0;
    logic signed [15:0] speed;
    logic               temp_hot;
    logic               temp_warm;
    logic [19:0]        temp_prod;
    logic [15:0]        volt_f;
  } s1_t;

  // Stage 2: temperature factor ready
  typedef struct packed {
    cause_e             cause;
    logic [14:0]        e0;
    logic signed [15:0] speed;
    logic [15:0]        temp_f;
    logic [15:0]        volt_f;
  } s2_t;

  // Stage 3: temperature derating applied
  typedef struct packed {
    cause_e             cause;
    logic [14:0]        e1;
    logic signed [15:0] speed;
    logic [15:0]        volt_f;
  } s3_t;

  // Stage 4: voltage derating applied
  typedef struct packed {
    cause_e             cause;
    logic [14:0]        e2;
    logic signed [15:0] speed;
  } s4_t;

  // Thresholds
  localparam logic signed [15:0] SPD_EMERGENCY = 16'sd9000;
  localparam logic signed [15:0] SPD_MAX_SAFE  = 16'sd8000;
  localparam logic signed [11:0] TEMP_WARN     = 12'sd600;
  localparam logic signed [11:0] TEMP_CRIT     = 12'sd750;
  localparam logic signed [11:0] TEMP_SHUT     = 12'sd850;
  localparam logic [15:0]        VOLT_FLOOR    = 16'd1000;
  localparam logic [15:0]        VOLT_SHUT     = 16'd38000;
  localparam logic [15:0]        VOLT_CRIT     = 16'd42000;
  localparam logic [15:0]        VOLT_WARN     = 16'd44000;

  // Q1.15 factors
  localparam logic [15:0] Q15_ONE = 16'd32768;
  localparam logic [15:0] Q15_P3  = 16'd9830;
  localparam logic [15:0] Q15_P4  = 16'd13107;
  localparam logic [15:0] Q15_P6  = 16'd19661;

  // Temperature slope 22938/150 reduced to 3823/25; divide by 25 via reciprocal
  localparam logic [11:0] TEMP_SLOPE   = 12'd3823;
  localparam logic [20:0] DIV25_RECIP  = 21'd1342178;

  // Brake: error threshold, saturation point, divide by 5 via reciprocal
  localparam logic signed [17:0] BRAKE_ERR_LIMIT = -18'sd200;
  localparam logic [17:0]        BRAKE_SAT_MAG   = 18'd2000;
  localparam logic [9:0]         DIV5_RECIP      = 10'd820;
  localparam logic [6:0]         BRAKE_MAX       = 7'd100;
  localparam logic [6:0]         BRAKE_MIN       = 7'd5;

endpackage

[rtl/core/vehicle_safety_speed_supervisor.sv]
// Vehicle safety speed supervisor: a five-stage pipeline that takes one
// sensor sample per beat and returns one result beat per sample. A sample
// can be accepted in every clock cycle while the input is not stalled; its
// result passes through the stage 1 to 4 registers into the output register
// and is taken at an edge where the output is not stalled.
// Each stage holds at most one multiplier, which sets the clock rate. A
// stall on the output holds the result and lets empty stages behind it
// fill, so the input is stalled only once all five stages hold a sample.
// The target speed register takes a write in any cycle and is read in the
// first stage; write it only while no sample is in flight.
module vehicle_safety_speed_supervisor
  import vsss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  pipe_en_t    en;
  logic [14:0] target_q;
  logic        v1_q, v2_q, v3_q, v4_q, vo_q;
  s2_t         s2;
  s4_t         s4;

  // Advance each stage when it is empty or the one after it moves
  always_comb begin
    en.so = !vo_q || !out_stall_i;
    en.s4 = !v4_q || en.so;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign in_stall_o  = !en.s1;
  assign out_valid_o = vo_q;
  assign cfg_ready_o = 1'b1;

  // Valid bits travel alongside the stage data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
      if (en.so) vo_q <= v4_q;
    end
  end

  // Target speed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      target_q <= cfg_data_i;
    end
  end

  vsss_screen u_screen (
    .clk_i     (clk_i),
    .en_i      (en),
    .in_data_i (in_data_i),
    .target_i  (target_q),
    .s2_o      (s2)
  );

  vsss_derate u_derate (
    .clk_i (clk_i),
    .en_i  (en),
    .s2_i  (s2),
    .s4_o  (s4)
  );

  vsss_brake u_brake (
    .clk_i      (clk_i),
    .en_i       (en),
    .s4_i       (s4),
    .out_data_o (out_data_o)
  );

endmodule

[rtl/core/vsss_screen.sv]
// Emergency checks and temperature factor (stages 1 and 2).
module vsss_screen
  import vsss_pkg::*;
(
  input  logic        clk_i,
  input  pipe_en_t    en_i,
  input  in_t         in_data_i,
  input  logic [14:0] target_i,
  output s2_t         s2_o
);

  s1_t         s1_d, s1_q;
  s2_t         s2_d, s2_q;
  logic [12:0] temp_diff;
  logic [40:0] div_prod;
  logic [14:0] div_q;

  // Stage 1: classify the sample and start the temperature slope product
  always_comb begin
    s1_d = '0;
    s1_d.speed = in_data_i.speed;

    if (in_data_i.obstacle) begin
      s1_d.cause = CAUSE_OBSTACLE;
    end else if (in_data_i.speed > SPD_EMERGENCY) begin
      s1_d.cause = CAUSE_OVERSPEED;
    end else if (in_data_i.temperature > TEMP_SHUT) begin
      s1_d.cause = CAUSE_OVERTEMP;
    end else if (in_data_i.voltage < VOLT_SHUT && in_data_i.voltage > VOLT_FLOOR) begin
      s1_d.cause = CAUSE_UNDERVOLT;
    end else begin
      s1_d.cause = CAUSE_NONE;
    end

    // Start from zero in the overspeed zone
    s1_d.e0 = (in_data_i.speed > SPD_MAX_SAFE) ? 15'd0 : target_i;

    s1_d.temp_hot  = in_data_i.temperature > TEMP_CRIT;
    s1_d.temp_warm = in_data_i.temperature > TEMP_WARN;
    temp_diff = {in_data_i.temperature[11], in_data_i.temperature} - {1'b0, TEMP_WARN};
    s1_d.temp_prod = 20'({12'd0, temp_diff[7:0]} * {8'd0, TEMP_SLOPE});

    if (in_data_i.voltage < VOLT_CRIT && in_data_i.voltage > VOLT_FLOOR) begin
      s1_d.volt_f = Q15_P4;
    end else if (in_data_i.voltage < VOLT_WARN && in_data_i.voltage > VOLT_FLOOR) begin
      s1_d.volt_f = Q15_P6;
    end else begin
      s1_d.volt_f = Q15_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: divide by 25 and pick the temperature factor
  always_comb begin
    div_prod = {21'd0, s1_q.temp_prod} * {20'd0, DIV25_RECIP};
    div_q    = div_prod[39:25];

    s2_d.cause  = s1_q.cause;
    s2_d.e0     = s1_q.e0;
    s2_d.speed  = s1_q.speed;
    s2_d.volt_f = s1_q.volt_f;
    if (s1_q.temp_hot) begin
      s2_d.temp_f = Q15_P3;
    end else if (s1_q.temp_warm) begin
      s2_d.temp_f = Q15_ONE - {1'b0, div_q};
    end else begin
      s2_d.temp_f = Q15_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

[rtl/core/vsss_derate.sv]
// Temperature and voltage derating multiplies (stages 3 and 4).
module vsss_derate
  import vsss_pkg::*;
(
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  s2_t      s2_i,
  output s4_t      s4_o
);

  s3_t         s3_d, s3_q;
  s4_t         s4_d, s4_q;
  logic [30:0] temp_scaled;
  logic [30:0] volt_scaled;

  // Stage 3: scale by the temperature factor, truncate
  always_comb begin
    temp_scaled  = {16'd0, s2_i.e0} * {15'd0, s2_i.temp_f};
    s3_d.cause   = s2_i.cause;
    s3_d.e1      = temp_scaled[29:15];
    s3_d.speed   = s2_i.speed;
    s3_d.volt_f  = s2_i.volt_f;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_q <= s3_d;
    end
  end

  // Stage 4: scale by the voltage factor, truncate
  always_comb begin
    volt_scaled = {16'd0, s3_q.e1} * {15'd0, s3_q.volt_f};
    s4_d.cause  = s3_q.cause;
    s4_d.e2     = volt_scaled[29:15];
    s4_d.speed  = s3_q.speed;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

endmodule

[rtl/core/vsss_brake.sv]
// Speed error, brake command and result register (stage 5).
module vsss_brake
  import vsss_pkg::*;
(
  input  logic     clk_i,
  input  pipe_en_t en_i,
  input  s4_t      s4_i,
  output out_t     out_data_o
);

  out_t               res_d, res_q;
  logic signed [17:0] err;
  logic [17:0]        err_mag;
  logic [18:0]        div_prod;
  logic [6:0]         brake_raw;

  // Cut power on an emergency cause, else brake on a large negative error, otherwise drive the motor
  always_comb begin
    err      = $signed({3'd0, s4_i.e2}) - $signed({{2{s4_i.speed[15]}}, s4_i.speed});
    err_mag  = 18'(-err);
    // |err|/20 as (|err|/4)/5, only needed below saturation
    div_prod = {10'd0, err_mag[10:2]} * {9'd0, DIV5_RECIP};
    if (err_mag >= BRAKE_SAT_MAG) begin
      brake_raw = BRAKE_MAX;
    end else if (div_prod[18:12] < BRAKE_MIN) begin
      brake_raw = BRAKE_MIN;
    end else begin
      brake_raw = div_prod[18:12];
    end

    res_d = '0;
    if (s4_i.cause != CAUSE_NONE) begin
      res_d.shutoff = 1'b1;
      res_d.cause   = s4_i.cause;
    end else if (err < BRAKE_ERR_LIMIT) begin
      res_d.cause     = CAUSE_NONE;
      res_d.brake_pct = brake_raw;
    end else begin
      res_d.cause        = CAUSE_NONE;
      res_d.motor_target = s4_i.e2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.so) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

endmodule

[rtl/core/vsss_checker.sv]
// Port-level checker for the speed supervisor, bound to the top level.
`include "vehicle_safety_speed_supervisor_defines.svh"

module vsss_checker
  import vsss_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_stall_i,
  input out_t out_data_i
);

  // A power cut carries a cause and commands neither brake nor motor
  `VSSS_ASSERT_IMP(a_cut_fields, clk_i, rst_ni, out_valid_i && out_data_i.shutoff, out_data_i.cause != CAUSE_NONE && out_data_i.brake_pct == 7'd0 && out_data_i.motor_target == 15'd0, "power cut beat with cause none or nonzero command")
  // Without a power cut no cause is reported
  `VSSS_ASSERT_IMP(a_no_cut_cause, clk_i, rst_ni, out_valid_i && !out_data_i.shutoff, out_data_i.cause == CAUSE_NONE, "cause reported without power cut")
  // Braking stays within 5..100 and stops the motor
  `VSSS_ASSERT_IMP(a_brake_range, clk_i, rst_ni, out_valid_i && out_data_i.brake_pct != 7'd0, out_data_i.motor_target == 15'd0 && out_data_i.brake_pct >= 7'd5 && out_data_i.brake_pct <= 7'd100, "brake beat out of range or motor driven")
  // A stalled result beat holds
  `VSSS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i), "stalled result beat changed")

endmodule

bind vehicle_safety_speed_supervisor vsss_checker u_vsss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

[bench/vehicle_safety_speed_supervisor_tb.sv]
// Self-checking testbench for the vehicle safety speed supervisor.
module vehicle_safety_speed_supervisor_tb;
  import vsss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_SAMPLES = 180;

  // Supervisor thresholds and Q1.15 factors, in bench terms
  localparam int OVERSPEED_LIM = 9000;
  localparam int SAFE_SPEED_LIM = 8000;
  localparam int HOT_SHUTDOWN = 850;
  localparam int HOT_CRITICAL = 750;
  localparam int HOT_WARNING = 600;
  localparam int VBAT_FLOOR = 1000;
  localparam int VBAT_SHUTDOWN = 38000;
  localparam int VBAT_CRITICAL = 42000;
  localparam int VBAT_WARNING = 44000;
  localparam int unsigned FRAC_ONE = 32768;
  localparam int unsigned FRAC_0P3 = 9830;
  localparam int unsigned FRAC_0P7 = 22938;
  localparam int unsigned FRAC_0P4 = 13107;
  localparam int unsigned FRAC_0P6 = 19661;
  localparam int BRAKE_ERR_THRESH = -200;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [14:0] cfg_data_i = '0;

  in_t         pending_samples[$];
  out_t        expected_cmds[$];
  logic [14:0] cruise_target = '0;
  logic        sample_taken = 1'b0;
  int          cyc = 0;
  int          mismatches = 0;

  vehicle_safety_speed_supervisor uut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the command the supervisor owes for one sample
  function automatic out_t predict_command(in_t s, logic [14:0] tgt);
    int          spd;
    int          tmp;
    int          vlt;
    int          err;
    int unsigned e;
    int unsigned f;
    int unsigned brk;
    out_t        r;
    spd = $signed(s.speed);
    tmp = $signed(s.temperature);
    vlt = s.voltage;
    r = '0;
    r.cause = CAUSE_NONE;
    if (s.obstacle) begin
      r.cause = CAUSE_OBSTACLE;
    end else if (spd > OVERSPEED_LIM) begin
      r.cause = CAUSE_OVERSPEED;
    end else if (tmp > HOT_SHUTDOWN) begin
      r.cause = CAUSE_OVERTEMP;
    end else if (vlt > VBAT_FLOOR && vlt < VBAT_SHUTDOWN) begin
      r.cause = CAUSE_UNDERVOLT;
    end
    if (r.cause != CAUSE_NONE) begin
      r.shutoff = 1'b1;
      return r;
    end
    // derate by temperature, then by battery voltage
    e = (spd > SAFE_SPEED_LIM) ? 0 : tgt;
    if (tmp > HOT_CRITICAL) begin
      e = (e * FRAC_0P3) >> 15;
    end else if (tmp > HOT_WARNING) begin
      f = FRAC_ONE - (int'(tmp - HOT_WARNING) * FRAC_0P7) / (HOT_CRITICAL - HOT_WARNING);
      e = (e * f) >> 15;
    end
    if (vlt > VBAT_FLOOR && vlt < VBAT_CRITICAL) begin
      e = (e * FRAC_0P4) >> 15;
    end else if (vlt > VBAT_FLOOR && vlt < VBAT_WARNING) begin
      e = (e * FRAC_0P6) >> 15;
    end
    // brake on a large negative error, else drive the motor
    err = int'(e) - spd;
    if (err < BRAKE_ERR_THRESH) begin
      brk = (-err) / 20;
      if (brk > 100) brk = 100;
      if (brk < 5) brk = 5;
      r.brake_pct = brk[6:0];
    end else begin
      r.motor_target = e[14:0];
    end
    return r;
  endfunction

  function automatic bit idle_roll();
    // hold a quiet stretch with no idling on either side
    if (cyc >= 300 && cyc < 900) return 1'b0;
    return $urandom_range(0, 99) < 8;
  endfunction

  task automatic queue_sample(int spd, int tmp, int vlt, bit obs);
    in_t s;
    s.speed = spd[15:0];
    s.temperature = tmp[11:0];
    s.voltage = vlt[15:0];
    s.obstacle = obs;
    pending_samples.push_back(s);
  endtask

  // Mostly plausible samples spread over the derating bands, some raw noise
  task automatic queue_random_sample();
    logic [63:0] raw;
    int          spd;
    int          tmp;
    int          vlt;
    if ($urandom_range(0, 99) < 6) begin
      raw = {$urandom, $urandom};
      pending_samples.push_back(raw[$bits(in_t)-1:0]);
      return;
    end
    case ($urandom_range(0, 9))
      0:       spd = $urandom_range(0, 40000) - 20000;
      1:       spd = $urandom_range(0, 65535) - 32768;
      2, 3:    spd = $urandom_range(7900, 9100);
      default: spd = $urandom_range(0, 11000) - 2000;
    endcase
    case ($urandom_range(0, 5))
      0, 1:    tmp = $urandom_range(0, 1000) - 400;
      2:       tmp = $urandom_range(590, 760);
      3:       tmp = $urandom_range(740, 860);
      4:       tmp = $urandom_range(851, 2000);
      default: tmp = $urandom_range(0, 4095) - 2048;
    endcase
    case ($urandom_range(0, 5))
      0:       vlt = $urandom_range(0, 1100);
      1:       vlt = $urandom_range(1001, 37999);
      2, 3:    vlt = $urandom_range(37000, 45000);
      4:       vlt = $urandom_range(44000, 65535);
      default: vlt = $urandom_range(0, 65535);
    endcase
    queue_sample(spd, tmp, vlt, $urandom_range(0, 14) == 0);
  endtask

  task automatic write_target(logic [14:0] v);
    @(negedge clk);
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_samples.size() != 0 || expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Drive sample beats and output stall on the falling edge
  always @(negedge clk) begin
    out_stall_i <= idle_roll();
    if (!(in_valid_i && !sample_taken)) begin
      if (pending_samples.size() != 0 && !idle_roll()) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_samples[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Check result beats, predict accepted sample beats, track the register
  always @(posedge clk) begin
    out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = expected_cmds.pop_front();
        if (out_data_o.shutoff !== want.shutoff)
          report_field("shutoff", want.shutoff, out_data_o.shutoff);
        if (out_data_o.cause !== want.cause)
          report_field("cause", want.cause, out_data_o.cause);
        if (out_data_o.brake_pct !== want.brake_pct)
          report_field("brake_pct", want.brake_pct, out_data_o.brake_pct);
        if (out_data_o.motor_target !== want.motor_target)
          report_field("motor_target", want.motor_target, out_data_o.motor_target);
      end
    end
    sample_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o) begin
      expected_cmds.push_back(predict_command(in_data_i, cruise_target));
      void'(pending_samples.pop_front());
    end
    if (cfg_valid_i && cfg_ready_o) cruise_target <= cfg_data_i;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_cmds.size());
      $display("** vehicle_safety_speed_supervisor: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [14:0] targets[6];
    targets = '{15'd0, 15'd20000, 15'd800, 15'd0, 15'd0, 15'd20000};
    targets[3] = $urandom_range(0, 20000);
    targets[4] = $urandom_range(0, 20000);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // a few beats against the reset target
    repeat (4) queue_random_sample();
    drain();

    // directed: priorities, threshold edges and brake boundaries
    write_target(15'd12000);
    queue_sample(9500, 900, 2000, 1'b1);
    queue_sample(9001, 900, 2000, 1'b0);
    queue_sample(32767, 0, 50000, 1'b0);
    queue_sample(9000, 500, 50000, 1'b0);
    queue_sample(8001, 250, 50000, 1'b0);
    queue_sample(0, 851, 2000, 1'b0);
    queue_sample(0, 850, 50000, 1'b0);
    queue_sample(0, 2047, 50000, 1'b0);
    queue_sample(0, -2048, 37999, 1'b0);
    queue_sample(0, 250, 1001, 1'b0);
    queue_sample(0, 250, 1000, 1'b0);
    queue_sample(0, 250, 0, 1'b0);
    queue_sample(0, 250, 38000, 1'b0);
    queue_sample(0, 250, 41999, 1'b0);
    queue_sample(0, 250, 42000, 1'b0);
    queue_sample(0, 250, 43999, 1'b0);
    queue_sample(0, 250, 44000, 1'b0);
    queue_sample(-32768, 600, 65535, 1'b0);
    queue_sample(-20000, 601, 50000, 1'b0);
    queue_sample(100, 675, 50000, 1'b0);
    queue_sample(100, 751, 50000, 1'b0);
    queue_sample(3799, 800, 50000, 1'b0);
    queue_sample(3800, 800, 50000, 1'b0);
    queue_sample(5598, 800, 50000, 1'b0);
    queue_sample(5599, 800, 50000, 1'b0);
    drain();

    // random phases over several cruise targets
    foreach (targets[i]) begin
      write_target(targets[i]);
      repeat (PHASE_SAMPLES) queue_random_sample();
      drain();
    end

    if (mismatches == 0) begin
      $display("** vehicle_safety_speed_supervisor: PASSED **");
    end else begin
      $display("** vehicle_safety_speed_supervisor: FAILED **");
    end
    $finish;
  end

endmodule
